[hw/rtl/sot_pkg.sv]
`timescale 1ns / 1ps

package sot_pkg;

  // shape codes of a descriptor
  localparam logic [1:0] SHAPE_RECT     = 2'd0;
  localparam logic [1:0] SHAPE_CIRCLE   = 2'd1;
  localparam logic [1:0] SHAPE_BOUNDARY = 2'd2;
  localparam logic [1:0] SHAPE_UNKNOWN  = 2'd3;

  // how the pair is resolved downstream
  localparam logic [1:0] MODE_FLAG = 2'd0;  // answer already known
  localparam logic [1:0] MODE_CR   = 2'd1;  // circle against rectangle
  localparam logic [1:0] MODE_CC   = 2'd2;  // circle against circle

  // position of a circle centre along one axis of a rectangle
  localparam logic [1:0] POS_BEFORE = 2'd0;
  localparam logic [1:0] POS_INSIDE = 2'd1;
  localparam logic [1:0] POS_AFTER  = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic       flag;
    logic [1:0] ry;
    logic [1:0] rx;
  } sot_ctrl_t;

  typedef struct packed {
    logic use_sq;
    logic flag;
  } sot_fin_t;

endpackage

[hw/rtl/sot_select.sv]
`timescale 1ns / 1ps

module sot_select import sot_pkg::*; #(
  parameter int W = 16
) (
  input  logic                clk,
  input  logic                en,
  input  logic                same_object,
  input  logic [1:0]          a_shape,
  input  logic signed [W-1:0] a_p0,
  input  logic signed [W-1:0] a_p1,
  input  logic signed [W-1:0] a_p2,
  input  logic signed [W-1:0] a_p3,
  input  logic [1:0]          b_shape,
  input  logic signed [W-1:0] b_p0,
  input  logic signed [W-1:0] b_p1,
  input  logic signed [W-1:0] b_p2,
  input  logic signed [W-1:0] b_p3,
  output sot_ctrl_t           ctrl_r,
  output logic signed [W:0]   c_cx_r,
  output logic signed [W:0]   c_cy_r,
  output logic signed [W:0]   c_rad_r,
  output logic signed [W:0]   c_l_r,
  output logic signed [W:0]   c_t_r,
  output logic signed [W:0]   c_r_r,
  output logic signed [W:0]   c_b_r,
  output logic signed [W:0]   q_p0_r,
  output logic signed [W:0]   q_p1_r,
  output logic signed [W:0]   q_p2_r,
  output logic signed [W:0]   q_p3_r
);

  logic signed [W:0] ae0, ae1, ae2, ae3, be0, be1, be2, be3;
  logic signed [W:0] al, at, ar, ab, bl, bt, br, bb;
  logic signed [W:0] o_l, o_t, o_r, o_b, d_l, d_t, d_r, d_b;
  logic signed [W:0] c_cx, c_cy, c_rad, c_l, c_t, c_r, c_b;
  logic signed [W:0] q_p0, q_p1, q_p2, q_p3;
  logic              a_circ, b_circ, swap, any_hit, box_hit;
  sot_ctrl_t         ctrl_nxt;

  assign ae0 = {a_p0[W-1], a_p0};
  assign ae1 = {a_p1[W-1], a_p1};
  assign ae2 = {a_p2[W-1], a_p2};
  assign ae3 = {a_p3[W-1], a_p3};
  assign be0 = {b_p0[W-1], b_p0};
  assign be1 = {b_p1[W-1], b_p1};
  assign be2 = {b_p2[W-1], b_p2};
  assign be3 = {b_p3[W-1], b_p3};

  assign a_circ = (a_shape == SHAPE_CIRCLE);
  assign b_circ = (b_shape == SHAPE_CIRCLE);

  // circle edges are centre plus or minus radius
  assign al = a_circ ? ae0 - ae2 : ae0;
  assign at = a_circ ? ae1 - ae2 : ae1;
  assign ar = a_circ ? ae0 + ae2 : ae2;
  assign ab = a_circ ? ae1 + ae2 : ae3;
  assign bl = b_circ ? be0 - be2 : be0;
  assign bt = b_circ ? be1 - be2 : be1;
  assign br = b_circ ? be0 + be2 : be2;
  assign bb = b_circ ? be1 + be2 : be3;

  // object against boundary, either order
  always_comb begin
    if (b_shape == SHAPE_BOUNDARY) begin
      o_l = al; o_t = at; o_r = ar; o_b = ab;
      d_l = bl; d_t = bt; d_r = br; d_b = bb;
    end else begin
      o_l = bl; o_t = bt; o_r = br; o_b = bb;
      d_l = al; d_t = at; d_r = ar; d_b = ab;
    end
  end

  assign any_hit = (o_l < d_r) || (o_t < d_b) || (o_r > d_l) || (o_b > d_t);
  assign box_hit = (al < br) && (at < bb) && (ar > bl) && (ab > bt);

  // put the circle in the c slot, the other shape's raw fields in q
  assign swap  = b_circ && (a_shape == SHAPE_RECT);
  assign c_cx  = swap ? be0 : ae0;
  assign c_cy  = swap ? be1 : ae1;
  assign c_rad = swap ? be2 : ae2;
  assign c_l   = swap ? bl : al;
  assign c_t   = swap ? bt : at;
  assign c_r   = swap ? br : ar;
  assign c_b   = swap ? bb : ab;
  assign q_p0  = swap ? ae0 : be0;
  assign q_p1  = swap ? ae1 : be1;
  assign q_p2  = swap ? ae2 : be2;
  assign q_p3  = swap ? ae3 : be3;

  always_comb begin
    ctrl_nxt.mode = MODE_FLAG;
    ctrl_nxt.flag = 1'b0;
    ctrl_nxt.rx   = (c_cx < q_p0) ? POS_BEFORE : ((c_cx <= q_p2) ? POS_INSIDE : POS_AFTER);
    ctrl_nxt.ry   = (c_cy < q_p1) ? POS_BEFORE : ((c_cy <= q_p3) ? POS_INSIDE : POS_AFTER);
    if (same_object || a_shape == SHAPE_UNKNOWN || b_shape == SHAPE_UNKNOWN) begin
      ctrl_nxt.flag = 1'b0;
    end else if (a_shape == SHAPE_BOUNDARY && b_shape == SHAPE_BOUNDARY) begin
      ctrl_nxt.flag = 1'b1;
    end else if (a_shape == SHAPE_BOUNDARY || b_shape == SHAPE_BOUNDARY) begin
      ctrl_nxt.flag = any_hit;
    end else if (a_shape == SHAPE_RECT && b_shape == SHAPE_RECT) begin
      ctrl_nxt.flag = box_hit;
    end else if (a_circ && b_circ) begin
      ctrl_nxt.mode = MODE_CC;
    end else begin
      ctrl_nxt.mode = MODE_CR;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl_r  <= ctrl_nxt;
      c_cx_r  <= c_cx;
      c_cy_r  <= c_cy;
      c_rad_r <= c_rad;
      c_l_r   <= c_l;
      c_t_r   <= c_t;
      c_r_r   <= c_r;
      c_b_r   <= c_b;
      q_p0_r  <= q_p0;
      q_p1_r  <= q_p1;
      q_p2_r  <= q_p2;
      q_p3_r  <= q_p3;
    end
  end

endmodule

[hw/rtl/sot_operand.sv]
`timescale 1ns / 1ps

module sot_operand import sot_pkg::*; #(
  parameter int W = 16
) (
  input  logic              clk,
  input  logic              en,
  input  sot_ctrl_t         ctrl,
  input  logic signed [W:0] c_cx,
  input  logic signed [W:0] c_cy,
  input  logic signed [W:0] c_rad,
  input  logic signed [W:0] c_l,
  input  logic signed [W:0] c_t,
  input  logic signed [W:0] c_r,
  input  logic signed [W:0] c_b,
  input  logic signed [W:0] q_p0,
  input  logic signed [W:0] q_p1,
  input  logic signed [W:0] q_p2,
  input  logic signed [W:0] q_p3,
  output sot_fin_t          fin_r,
  output logic signed [W:0] dy_r,
  output logic signed [W:0] dx_r,
  output logic signed [W:0] rr_r
);

  sot_fin_t          fin_nxt;
  logic signed [W:0] dy_nxt, dx_nxt, rr_nxt;

  always_comb begin
    fin_nxt.use_sq = 1'b0;
    fin_nxt.flag   = ctrl.flag;
    dy_nxt = (ctrl.ry == POS_BEFORE) ? q_p1 - c_cy : c_cy - q_p3;
    dx_nxt = (ctrl.rx == POS_BEFORE) ? q_p0 - c_cx : c_cx - q_p2;
    rr_nxt = c_rad;
    case (ctrl.mode)
      MODE_CC: begin
        fin_nxt.use_sq = 1'b1;
        dy_nxt = c_cy - q_p1;
        dx_nxt = c_cx - q_p0;
        rr_nxt = c_rad + q_p2;
      end
      MODE_CR: begin
        if (ctrl.ry == POS_INSIDE) begin
          fin_nxt.flag = (c_l < q_p2) && (c_r > q_p0);
        end else if (ctrl.rx == POS_INSIDE) begin
          fin_nxt.flag = (ctrl.ry == POS_BEFORE) ? (c_b > q_p1) : (c_t < q_p3);
        end else begin
          // corner region: distance to the nearest corner
          fin_nxt.use_sq = 1'b1;
        end
      end
      default: begin
        fin_nxt.use_sq = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_r <= fin_nxt;
      dy_r  <= dy_nxt;
      dx_r  <= dx_nxt;
      rr_r  <= rr_nxt;
    end
  end

endmodule

[hw/rtl/sot_square.sv]
`timescale 1ns / 1ps

module sot_square import sot_pkg::*; #(
  parameter int W = 16
) (
  input  logic              clk,
  input  logic              en,
  input  sot_fin_t          fin,
  input  logic signed [W:0] dy,
  input  logic signed [W:0] dx,
  input  logic signed [W:0] rr,
  output sot_fin_t          fin_r,
  output logic [2*W+1:0]    sy_r,
  output logic [2*W+1:0]    sx_r,
  output logic [2*W+1:0]    sr_r
);

  logic signed [2*W+1:0] py, px, pr;

  // squares are never negative and fit in 2w+2 bits
  assign py = dy * dy;
  assign px = dx * dx;
  assign pr = rr * rr;

  always_ff @(posedge clk) begin
    if (en) begin
      fin_r <= fin;
      sy_r  <= $unsigned(py);
      sx_r  <= $unsigned(px);
      sr_r  <= $unsigned(pr);
    end
  end

endmodule

[hw/rtl/shape_overlap_test.sv]
`timescale 1ns / 1ps

// shape overlap test: takes one pair of shape descriptors per word and returns one hit
// flag per word, in order. each shape is a rectangle or boundary (absolute left, top,
// right, bottom edges) or a circle (centre x, centre y, radius), in signed Q12.4 at
// COORD_WIDTH bits. a new word can be taken every cycle while in_ready is high; each word
// passes through the select, operand, square and compare stages, and the output register
// holds a finished hit while new words keep flowing whenever out_ready is high. a stall
// on the output side freezes the full output stage and every full stage directly behind
// it, so nothing is lost or repeated. all products are exact; nothing is rounded or saturated.

module shape_overlap_test import sot_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_same_object,
  input  logic [1:0]                    in_a_shape,
  input  logic signed [COORD_WIDTH-1:0] in_a_p0,
  input  logic signed [COORD_WIDTH-1:0] in_a_p1,
  input  logic signed [COORD_WIDTH-1:0] in_a_p2,
  input  logic signed [COORD_WIDTH-1:0] in_a_p3,
  input  logic [1:0]                    in_b_shape,
  input  logic signed [COORD_WIDTH-1:0] in_b_p0,
  input  logic signed [COORD_WIDTH-1:0] in_b_p1,
  input  logic signed [COORD_WIDTH-1:0] in_b_p2,
  input  logic signed [COORD_WIDTH-1:0] in_b_p3,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_hit
);

  localparam int W = COORD_WIDTH;

  // per-stage valid bits and advance enables
  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  // stage 1 outputs
  sot_ctrl_t         ctrl1;
  logic signed [W:0] c_cx, c_cy, c_rad, c_l, c_t, c_r, c_b;
  logic signed [W:0] q_p0, q_p1, q_p2, q_p3;

  // stage 2 outputs
  sot_fin_t          fin2;
  logic signed [W:0] dy, dx, rr;

  // stage 3 outputs
  sot_fin_t          fin3;
  logic [2*W+1:0]    sy, sx, sr;

  // stage 4: final compare
  logic [2*W+2:0]    sq_sum;
  logic              hit_r, hit_nxt;

  // a stage moves on when it is empty or its successor moves
  assign en4 = !v4_r || out_ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // stage 1: circle edges, boundary and box tests, operand steering, region classing
  sot_select #(.W(W)) u_select (
    .clk         (clk),
    .en          (en1),
    .same_object (in_same_object),
    .a_shape     (in_a_shape),
    .a_p0        (in_a_p0),
    .a_p1        (in_a_p1),
    .a_p2        (in_a_p2),
    .a_p3        (in_a_p3),
    .b_shape     (in_b_shape),
    .b_p0        (in_b_p0),
    .b_p1        (in_b_p1),
    .b_p2        (in_b_p2),
    .b_p3        (in_b_p3),
    .ctrl_r      (ctrl1),
    .c_cx_r      (c_cx),
    .c_cy_r      (c_cy),
    .c_rad_r     (c_rad),
    .c_l_r       (c_l),
    .c_t_r       (c_t),
    .c_r_r       (c_r),
    .c_b_r       (c_b),
    .q_p0_r      (q_p0),
    .q_p1_r      (q_p1),
    .q_p2_r      (q_p2),
    .q_p3_r      (q_p3)
  );

  // stage 2: edge-crossing flags or the differences to be squared
  sot_operand #(.W(W)) u_operand (
    .clk   (clk),
    .en    (en2),
    .ctrl  (ctrl1),
    .c_cx  (c_cx),
    .c_cy  (c_cy),
    .c_rad (c_rad),
    .c_l   (c_l),
    .c_t   (c_t),
    .c_r   (c_r),
    .c_b   (c_b),
    .q_p0  (q_p0),
    .q_p1  (q_p1),
    .q_p2  (q_p2),
    .q_p3  (q_p3),
    .fin_r (fin2),
    .dy_r  (dy),
    .dx_r  (dx),
    .rr_r  (rr)
  );

  // stage 3: three squares in parallel
  sot_square #(.W(W)) u_square (
    .clk   (clk),
    .en    (en3),
    .fin   (fin2),
    .dy    (dy),
    .dx    (dx),
    .rr    (rr),
    .fin_r (fin3),
    .sy_r  (sy),
    .sx_r  (sx),
    .sr_r  (sr)
  );

  // stage 4: squared distance strictly below squared radius, or the flag passed through
  assign sq_sum  = {1'b0, sy} + {1'b0, sx};
  assign hit_nxt = fin3.use_sq ? (sq_sum < {1'b0, sr}) : fin3.flag;

  always_ff @(posedge clk) begin
    if (en4) begin
      hit_r <= hit_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_hit   = hit_r;

endmodule
